// ===== hdl/lca_pkg.sv =====
// Shared widths, codes and port structs for the binary-lifting LCA block.
// No dependencies; every other file imports this package.
package lca_pkg;

   localparam int NODE_W   = 10;
   localparam int DEPTH_W  = 11;
   localparam int DIST_W   = 32;
   localparam int WEIGHT_W = 16;
   localparam int ACT_W    = 2;
   localparam int STAT_W   = 2;
   localparam int LVL_MAX_W = 5;

   localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
   localparam logic [ACT_W-1:0] ACT_QUERY  = 2'd1;
   localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd2;

   localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
   localparam logic [STAT_W-1:0] STAT_UNKNOWN = 2'd1;
   localparam logic [STAT_W-1:0] STAT_PRESENT = 2'd2;

   typedef struct packed {
      logic [NODE_W-1:0] anc;
      logic [DIST_W-1:0] wsum;
   } lift_entry_type;

   typedef struct packed {
      logic               we;
      logic [NODE_W-1:0]  waddr;
      logic [DEPTH_W-1:0] wdata;
      logic [NODE_W-1:0]  raddr;
   } dep_port_type;

   typedef struct packed {
      logic                 we;
      logic [NODE_W-1:0]    wnode;
      logic [LVL_MAX_W-1:0] wlvl;
      lift_entry_type       wdata;
      logic [NODE_W-1:0]    rnode;
      logic [LVL_MAX_W-1:0] rlvl;
   } lift_port_type;

endpackage

// ===== hdl/lca_chan_if.sv =====
// Valid/ready channel interfaces for request and response items.
// Depends on lca_pkg.
interface lca_req_if;
   import lca_pkg::*;
   logic                valid;
   logic                ready;
   logic [ACT_W-1:0]    action;
   logic [NODE_W-1:0]   node;
   logic [NODE_W-1:0]   parent_node;
   logic [WEIGHT_W-1:0] weight;
   logic [NODE_W-1:0]   other_node;
   modport source (output valid, action, node, parent_node, weight, other_node, input ready);
   modport sink (input valid, action, node, parent_node, weight, other_node, output ready);
endinterface

interface lca_rsp_if;
   import lca_pkg::*;
   logic               valid;
   logic               ready;
   logic [NODE_W-1:0]  ancestor;
   logic [DIST_W-1:0]  distance;
   logic [DEPTH_W-1:0] node_depth;
   logic [STAT_W-1:0]  status;
   modport source (output valid, ancestor, distance, node_depth, status, input ready);
   modport sink (input valid, ancestor, distance, node_depth, status, output ready);
endinterface

// ===== hdl/lca_depth_ram.sv =====
// Depth memory: one entry per node, one write and one registered read per cycle.
// Depends on lca_pkg.
module lca_depth_ram #(
   parameter int ROWS = 1024
) (
   input  logic                  clock,
   input  lca_pkg::dep_port_type port_in,
   output logic [lca_pkg::DEPTH_W-1:0] rd_data
);
   import lca_pkg::*;
   localparam int IDX_W = $clog2(ROWS);

   logic [DEPTH_W-1:0] mem [ROWS];

   always_ff @(posedge clock) begin
      if (port_in.we) begin
         mem[port_in.waddr[IDX_W-1:0]] <= port_in.wdata;
      end
      rd_data <= mem[port_in.raddr[IDX_W-1:0]];
   end
endmodule

// ===== hdl/lca_lift_ram.sv =====
// Lifting memory: ancestor and distance per node and level, registered read.
// Row of node 0 always reads as zero. Depends on lca_pkg.
module lca_lift_ram #(
   parameter int ROWS   = 1024,
   parameter int LEVELS = 11
) (
   input  logic                    clock,
   input  lca_pkg::lift_port_type  port_in,
   output lca_pkg::lift_entry_type rd_data
);
   import lca_pkg::*;
   localparam int IDX_W = $clog2(ROWS);
   localparam int LVL_W = $clog2(LEVELS);

   lift_entry_type mem [ROWS << LVL_W];
   lift_entry_type rd_ff;
   logic           zero_ff;

   always_ff @(posedge clock) begin
      if (port_in.we) begin
         mem[{port_in.wnode[IDX_W-1:0], port_in.wlvl[LVL_W-1:0]}] <= port_in.wdata;
      end
      rd_ff   <= mem[{port_in.rnode[IDX_W-1:0], port_in.rlvl[LVL_W-1:0]}];
      zero_ff <= (port_in.rnode == '0);
   end

   // node 0 has no ancestors; mask whatever the array holds there
   assign rd_data = zero_ff ? '0 : rd_ff;
endmodule

// ===== hdl/tree_lca_binary_lifting.sv =====
// Binary-lifting LCA engine: insert, query and clear over a weighted forest.
// Insert writes the lifting levels in turn; query lifts the deeper node, then both;
// both bound by one read of the lifting memory per cycle. One item at a time.
// Clear and reset: a sweep over min(MAX_NODES,1024) rows zeroes the depth memory,
// with the request channel held off; stale lifting rows are rewritten on insert.
// Reset is synchronous, active high. A result waits in an output register.
module tree_lca_binary_lifting #(
   parameter int MAX_NODES = 1024,
   parameter int TOP_LEVEL = 10
) (
   input logic      clock,
   input logic      reset,
   lca_req_if.sink   req_chan,
   lca_rsp_if.source rsp_chan
);
   import lca_pkg::*;

   localparam int ROWS   = (MAX_NODES < (1 << NODE_W)) ? MAX_NODES : (1 << NODE_W);
   localparam int IDX_W  = $clog2(ROWS);
   localparam int LEVELS = TOP_LEVEL + 1;
   localparam int LVL_W  = $clog2(LEVELS);
   localparam logic [LVL_W-1:0] LVL_TOP = LVL_W'(LEVELS - 1);

   typedef enum logic [12:0] {
      ST_IDLE  = 13'b0000000000001,
      ST_CLEAR = 13'b0000000000010,
      ST_RD_N  = 13'b0000000000100,
      ST_RD_P  = 13'b0000000001000,
      ST_INS   = 13'b0000000010000,
      ST_UP_D  = 13'b0000000100000,
      ST_UP_C  = 13'b0000001000000,
      ST_LF_Y  = 13'b0000010000000,
      ST_LF_X  = 13'b0000100000000,
      ST_FN_X  = 13'b0001000000000,
      ST_FN_Y  = 13'b0010000000000,
      ST_FIN   = 13'b0100000000000,
      ST_RESP  = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;
   logic [IDX_W-1:0]    clr_ff, clr_in;
   logic                pend_ff, pend_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // item context
   logic [ACT_W-1:0]    op_ff, op_in;
   logic [NODE_W-1:0]   n_ff, n_in, p_ff, p_in, b_ff, b_in;
   logic [WEIGHT_W-1:0] w_ff, w_in;
   logic [DEPTH_W-1:0]  dn_ff, dn_in;
   // walk registers
   logic [NODE_W-1:0]   x_ff, x_in, y_ff, y_in, ya_ff, ya_in;
   logic [DEPTH_W-1:0]  dx_ff, dx_in, dy_ff, dy_in;
   logic [DIST_W-1:0]   yd_ff, yd_in, sum_ff, sum_in;
   logic [LVL_W-1:0]    k_ff, k_in;
   // pending result and output register
   logic [NODE_W-1:0]   res_anc_ff, res_anc_in, out_anc_ff, out_anc_in;
   logic [DIST_W-1:0]   res_dist_ff, res_dist_in, out_dist_ff, out_dist_in;
   logic [DEPTH_W-1:0]  res_dep_ff, res_dep_in, out_dep_ff, out_dep_in;
   logic [STAT_W-1:0]   res_stat_ff, res_stat_in, out_stat_ff, out_stat_in;

   dep_port_type        dep_port;
   lift_port_type       lift_port;
   logic [DEPTH_W-1:0]  dep_rd;
   lift_entry_type      lift_rd;

   // scratch
   logic                cond;
   logic                differ;
   logic [NODE_W-1:0]   x_nx, y_nx;
   logic [DEPTH_W-1:0]  new_depth;
   logic [DIST_W-1:0]   up_dist;
   logic                out_free;

   function automatic logic node_ok(input logic [NODE_W-1:0] nd);
      return (nd != '0) && ({22'b0, nd} < 32'(MAX_NODES));
   endfunction

   lca_depth_ram #(.ROWS(ROWS)) u_depth (
      .clock   (clock),
      .port_in (dep_port),
      .rd_data (dep_rd)
   );

   lca_lift_ram #(.ROWS(ROWS), .LEVELS(LEVELS)) u_lift (
      .clock   (clock),
      .port_in (lift_port),
      .rd_data (lift_rd)
   );

   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      pend_in      = pend_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      op_in = op_ff; n_in = n_ff; p_in = p_ff; b_in = b_ff; w_in = w_ff; dn_in = dn_ff;
      x_in = x_ff; y_in = y_ff; ya_in = ya_ff; dx_in = dx_ff; dy_in = dy_ff;
      yd_in = yd_ff; sum_in = sum_ff; k_in = k_ff;
      res_anc_in = res_anc_ff; res_dist_in = res_dist_ff;
      res_dep_in = res_dep_ff; res_stat_in = res_stat_ff;
      out_anc_in = out_anc_ff; out_dist_in = out_dist_ff;
      out_dep_in = out_dep_ff; out_stat_in = out_stat_ff;
      dep_port  = '0;
      lift_port = '0;
      req_chan.ready = 1'b0;
      cond      = 1'b0;
      differ    = 1'b0;
      x_nx      = x_ff;
      y_nx      = y_ff;
      new_depth = (p_ff == '0) ? DEPTH_W'(1) : dep_rd + DEPTH_W'(1);
      up_dist   = lift_rd.wsum + yd_ff;

      unique case (state_ff)
         ST_IDLE: begin
            req_chan.ready = 1'b1;
            dep_port.raddr = req_chan.node;
            if (req_chan.valid) begin
               op_in = req_chan.action;
               n_in  = req_chan.node;
               p_in  = req_chan.parent_node;
               w_in  = req_chan.weight;
               b_in  = req_chan.other_node;
               res_anc_in  = '0;
               res_dist_in = '0;
               res_dep_in  = '0;
               res_stat_in = STAT_OK;
               sum_in      = '0;
               if (req_chan.action == ACT_INSERT || req_chan.action == ACT_QUERY) begin
                  state_in = ST_RD_N;
               end else if (req_chan.action == ACT_CLEAR) begin
                  clr_in   = '0;
                  pend_in  = 1'b1;
                  state_in = ST_CLEAR;
               end else begin
                  state_in = ST_RESP;
               end
            end
         end

         ST_CLEAR: begin
            dep_port.we    = 1'b1;
            dep_port.waddr = NODE_W'(clr_ff);
            dep_port.wdata = '0;
            if (clr_ff == IDX_W'(ROWS - 1)) begin
               state_in = pend_ff ? ST_RESP : ST_IDLE;
               pend_in  = 1'b0;
            end else begin
               clr_in = clr_ff + IDX_W'(1);
            end
         end

         ST_RD_N: begin
            dn_in          = dep_rd;
            dep_port.raddr = (op_ff == ACT_INSERT) ? p_ff : b_ff;
            state_in       = ST_RD_P;
         end

         ST_RD_P: begin
            if (op_ff == ACT_INSERT) begin
               if (!node_ok(n_ff)) begin
                  res_stat_in = STAT_UNKNOWN;
                  state_in    = ST_RESP;
               end else if (dn_ff != '0) begin
                  res_stat_in = STAT_PRESENT;
                  state_in    = ST_RESP;
               end else if (p_ff != '0 && (!node_ok(p_ff) || dep_rd == '0)) begin
                  res_stat_in = STAT_UNKNOWN;
                  state_in    = ST_RESP;
               end else begin
                  // commit depth and level 0, then chain up from the parent's rows
                  dep_port.we    = 1'b1;
                  dep_port.waddr = n_ff;
                  dep_port.wdata = new_depth;
                  res_dep_in     = new_depth;
                  lift_port.we   = 1'b1;
                  lift_port.wnode = n_ff;
                  lift_port.wlvl  = '0;
                  lift_port.wdata.anc  = p_ff;
                  lift_port.wdata.wsum = (p_ff == '0) ? '0 : DIST_W'(w_ff);
                  ya_in = p_ff;
                  yd_in = (p_ff == '0) ? '0 : DIST_W'(w_ff);
                  lift_port.rnode = p_ff;
                  lift_port.rlvl  = '0;
                  k_in     = LVL_W'(1);
                  state_in = ST_INS;
               end
            end else begin
               if (!node_ok(n_ff) || !node_ok(b_ff) || dn_ff == '0 || dep_rd == '0) begin
                  res_stat_in = STAT_UNKNOWN;
                  state_in    = ST_RESP;
               end else begin
                  // x is the shallower node
                  if (dn_ff > dep_rd) begin
                     x_nx = b_ff; dx_in = dep_rd; y_nx = n_ff; dy_in = dn_ff;
                  end else begin
                     x_nx = n_ff; dx_in = dn_ff; y_nx = b_ff; dy_in = dep_rd;
                  end
                  x_in = x_nx;
                  y_in = y_nx;
                  k_in = LVL_TOP;
                  lift_port.rnode = y_nx;
                  lift_port.rlvl  = LVL_MAX_W'(LVL_TOP);
                  state_in = ST_UP_D;
               end
            end
         end

         // ya/yd hold the new node's row at level k-1; lift_rd is mid's row k-1
         ST_INS: begin
            lift_port.we    = 1'b1;
            lift_port.wnode = n_ff;
            lift_port.wlvl  = LVL_MAX_W'(k_ff);
            lift_port.wdata.anc  = lift_rd.anc;
            lift_port.wdata.wsum = (lift_rd.anc == '0) ? '0 : up_dist;
            ya_in = lift_rd.anc;
            yd_in = (lift_rd.anc == '0) ? '0 : up_dist;
            lift_port.rnode = lift_rd.anc;
            lift_port.rlvl  = LVL_MAX_W'(k_ff);
            if (k_ff == LVL_TOP) begin
               state_in = ST_RESP;
            end else begin
               k_in = k_ff + LVL_W'(1);
            end
         end

         ST_UP_D: begin
            ya_in = lift_rd.anc;
            yd_in = lift_rd.wsum;
            dep_port.raddr = lift_rd.anc;
            state_in = ST_UP_C;
         end

         ST_UP_C: begin
            cond = (dx_ff < dy_ff) && (dep_rd >= dx_ff);
            if (cond) begin
               sum_in = sum_ff + yd_ff;
               y_nx   = ya_ff;
               dy_in  = dep_rd;
            end
            y_in = y_nx;
            if (k_ff == '0) begin
               if (x_ff == y_nx) begin
                  dep_port.raddr = x_ff;
                  state_in = ST_FIN;
               end else begin
                  k_in = LVL_TOP;
                  lift_port.rnode = y_nx;
                  lift_port.rlvl  = LVL_MAX_W'(LVL_TOP);
                  state_in = ST_LF_Y;
               end
            end else begin
               k_in = k_ff - LVL_W'(1);
               lift_port.rnode = y_nx;
               lift_port.rlvl  = LVL_MAX_W'(k_ff - LVL_W'(1));
               state_in = ST_UP_D;
            end
         end

         ST_LF_Y: begin
            ya_in = lift_rd.anc;
            yd_in = lift_rd.wsum;
            lift_port.rnode = x_ff;
            lift_port.rlvl  = LVL_MAX_W'(k_ff);
            state_in = ST_LF_X;
         end

         ST_LF_X: begin
            differ = (ya_ff != lift_rd.anc);
            if (differ) begin
               sum_in = sum_ff + yd_ff + lift_rd.wsum;
               y_nx   = ya_ff;
               x_nx   = lift_rd.anc;
            end
            x_in = x_nx;
            y_in = y_nx;
            if (k_ff == '0) begin
               lift_port.rnode = x_nx;
               lift_port.rlvl  = '0;
               state_in = ST_FN_X;
            end else begin
               k_in = k_ff - LVL_W'(1);
               lift_port.rnode = y_nx;
               lift_port.rlvl  = LVL_MAX_W'(k_ff - LVL_W'(1));
               state_in = ST_LF_Y;
            end
         end

         ST_FN_X: begin
            sum_in = sum_ff + lift_rd.wsum;
            ya_in  = lift_rd.anc;
            lift_port.rnode = y_ff;
            lift_port.rlvl  = '0;
            state_in = ST_FN_Y;
         end

         ST_FN_Y: begin
            sum_in = sum_ff + lift_rd.wsum;
            x_in   = ya_ff;
            dep_port.raddr = ya_ff;
            state_in = ST_FIN;
         end

         ST_FIN: begin
            if (x_ff == '0) begin
               res_stat_in = STAT_UNKNOWN;
            end else begin
               res_anc_in  = x_ff;
               res_dist_in = sum_ff;
               res_dep_in  = dep_rd;
               res_stat_in = STAT_OK;
            end
            state_in = ST_RESP;
         end

         ST_RESP: begin
            // hold the result until the output register frees up
            if (out_free) begin
               out_anc_in   = res_anc_ff;
               out_dist_in  = res_dist_ff;
               out_dep_in   = res_dep_ff;
               out_stat_in  = res_stat_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in; n_ff <= n_in; p_ff <= p_in; b_ff <= b_in; w_ff <= w_in;
      dn_ff <= dn_in;
      x_ff <= x_in; y_ff <= y_in; ya_ff <= ya_in; dx_ff <= dx_in; dy_ff <= dy_in;
      yd_ff <= yd_in; sum_ff <= sum_in; k_ff <= k_in;
      res_anc_ff <= res_anc_in; res_dist_ff <= res_dist_in;
      res_dep_ff <= res_dep_in; res_stat_ff <= res_stat_in;
      out_anc_ff <= out_anc_in; out_dist_ff <= out_dist_in;
      out_dep_ff <= out_dep_in; out_stat_ff <= out_stat_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.ancestor   = out_anc_ff;
   assign rsp_chan.distance   = out_dist_ff;
   assign rsp_chan.node_depth = out_dep_ff;
   assign rsp_chan.status     = out_stat_ff;
endmodule

// ===== hdl/lca_checker.sv =====
// Port-level checks for the LCA engine, bound onto the top level.
// Depends on lca_pkg and tree_lca_binary_lifting.
module lca_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [lca_pkg::NODE_W-1:0]    rsp_ancestor,
   input logic [lca_pkg::DIST_W-1:0]    rsp_distance,
   input logic [lca_pkg::DEPTH_W-1:0]   rsp_node_depth,
   input logic [lca_pkg::STAT_W-1:0]    rsp_status
);
   import lca_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped before taken");

   a_stat_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == STAT_OK || rsp_status == STAT_UNKNOWN ||
                     rsp_status == STAT_PRESENT))
      else $error("undefined status code");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STAT_OK |->
         rsp_ancestor == '0 && rsp_distance == '0 && rsp_node_depth == '0)
      else $error("error response carries data");

   a_anc_depth: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STAT_OK && rsp_ancestor != '0 |-> rsp_node_depth != '0)
      else $error("ancestor reported without depth");

   a_sweep: assert property (@(posedge clock) disable iff (reset)
      $fell(reset) |-> !(req_valid && req_ready))
      else $error("request taken during post-reset sweep");
endmodule

bind tree_lca_binary_lifting lca_checker u_lca_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_ancestor   (rsp_chan.ancestor),
   .rsp_distance   (rsp_chan.distance),
   .rsp_node_depth (rsp_chan.node_depth),
   .rsp_status     (rsp_chan.status)
);
